@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mcfb_pkg.sv @@
`timescale 1ns / 1ps
package mcfb_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned ByteIdxW   = 3;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgReceiverId = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSenderId   = 1'b1;

  localparam logic [7:0] ReceiverIdReset = 8'd183;
  localparam logic [7:0] SenderIdReset   = 8'd172;
  localparam logic [7:0] IdSetMotor      = 8'd254;
  localparam logic [7:0] DefaultData     = 8'h55;
  localparam logic [7:0] KeyData         = 8'hAA;
  localparam logic [7:0] FlagData        = 8'h01;

  typedef enum logic [3:0] {
    ReqDefault      = 4'd0,
    ReqTorqueOff    = 4'd1,
    ReqBrake        = 4'd2,
    ReqCmd          = 4'd3,
    ReqAlarmReset   = 4'd4,
    ReqPosReset     = 4'd5,
    ReqMainBc       = 4'd6,
    ReqMonitorBc    = 4'd7,
    ReqPresetSave   = 4'd8,
    ReqPresetRecall = 4'd9,
    ReqVel          = 4'd10,
    ReqVelX10       = 4'd11,
    ReqOpenVel      = 4'd12,
    ReqIdSet        = 4'd13,
    ReqBaud         = 4'd14
  } req_kind_e;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         motor_id;
    logic [3:0]         req_type;
  } req_t;

  typedef struct packed {
    logic [FrameBytes-1:0][7:0] bytes;
    logic [ByteIdxW-1:0]        last_idx;
    logic                       err;
  } frame_t;

endpackage

@@ src/mcfb_encode.sv @@
`timescale 1ns / 1ps
module mcfb_encode (
  input  mcfb_pkg::req_t   req_i,
  input  logic [7:0]       receiver_id_i,
  input  logic [7:0]       sender_id_i,
  output mcfb_pkg::frame_t frame_o
);
  import mcfb_pkg::*;

  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [15:0] x10;
  logic [7:0]  motor;
  logic [7:0]  param;
  logic [7:0]  d0;
  logic [7:0]  d1;
  logic        two;
  logic        bad;
  logic [7:0]  sum;
  logic [7:0]  chk;

  assign lo  = req_i.value[7:0];
  assign hi  = req_i.value[15:8];
  // value * 10 wrapped to 16 bits
  assign x10 = {req_i.value[12:0], 3'b000} + {req_i.value[14:0], 1'b0};

  always_comb begin
    motor = req_i.motor_id;
    param = 8'd0;
    d0    = 8'd0;
    d1    = 8'd0;
    two   = 1'b0;
    bad   = 1'b0;
    case (req_i.req_type)
      ReqDefault:    begin param = 8'd3;  d0 = DefaultData; end
      ReqTorqueOff:  begin param = 8'd5;  d0 = FlagData; end
      ReqBrake:      begin param = 8'd6;  d0 = FlagData; end
      ReqCmd:        begin param = 8'd10; d0 = lo; end
      ReqAlarmReset: begin param = 8'd12; d0 = FlagData; end
      ReqPosReset:   begin param = 8'd13; d0 = FlagData; end
      ReqMainBc:     begin param = 8'd14; d0 = lo; end
      ReqMonitorBc:  begin param = 8'd15; d0 = lo; end
      ReqPresetSave, ReqPresetRecall: begin
        bad   = (req_i.value < 16'sd1) || (req_i.value > 16'sd20);
        param = (req_i.req_type == ReqPresetSave) ? 8'd31 : 8'd32;
        d0    = lo;
      end
      ReqVel: begin
        param = 8'd130; two = 1'b1; d0 = lo; d1 = hi;
      end
      ReqVelX10: begin
        param = 8'd131; two = 1'b1; d0 = x10[7:0]; d1 = x10[15:8];
      end
      ReqOpenVel: begin
        bad   = (req_i.value < -16'sd1023) || (req_i.value > 16'sd1023);
        param = 8'd134; two = 1'b1; d0 = lo; d1 = hi;
      end
      ReqIdSet: begin
        bad   = (req_i.value < 16'sd1) || (req_i.value > 16'sd253);
        param = 8'd133; two = 1'b1; motor = IdSetMotor; d0 = KeyData; d1 = lo;
      end
      ReqBaud: begin
        param = 8'd135; two = 1'b1; d0 = KeyData; d1 = lo;
      end
      default: bad = 1'b1;
    endcase
  end

  assign sum = receiver_id_i + sender_id_i + motor + param + {6'd0, two, ~two} + d0 + d1;
  assign chk = 8'd0 - sum;

  always_comb begin
    frame_o = '0;
    if (bad) begin
      frame_o.err      = 1'b1;
      frame_o.last_idx = '0;
    end else begin
      frame_o.bytes[0] = receiver_id_i;
      frame_o.bytes[1] = sender_id_i;
      frame_o.bytes[2] = motor;
      frame_o.bytes[3] = param;
      frame_o.bytes[4] = {6'd0, two, ~two};
      frame_o.bytes[5] = d0;
      frame_o.bytes[6] = two ? d1 : chk;
      frame_o.bytes[7] = chk;
      frame_o.last_idx = two ? ByteIdxW'(7) : ByteIdxW'(6);
    end
  end

endmodule

@@ src/mcfb_serializer.sv @@
`timescale 1ns / 1ps
module mcfb_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_valid_i,
  input  mcfb_pkg::frame_t frame_i,
  output logic             frame_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             out_err_o
);
  import mcfb_pkg::*;

  logic                frame_valid_q, frame_valid_d;
  frame_t              frame_q;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  logic                out_err_q;
  logic                out_load;
  logic                at_last;
  logic                frame_load;

  assign out_load      = !out_valid_q || out_ready_i;
  assign at_last       = (idx_q == frame_q.last_idx);
  assign frame_ready_o = !frame_valid_q || (out_load && at_last);
  assign frame_load    = frame_valid_i && frame_ready_o;

  always_comb begin
    frame_valid_d = frame_valid_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q;
    if (out_load) begin
      out_valid_d = frame_valid_q;
      if (frame_valid_q) begin
        idx_d = idx_q + 1'b1;
        if (at_last) begin
          frame_valid_d = 1'b0;
        end
      end
    end
    if (frame_load) begin
      frame_valid_d = 1'b1;
      idx_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      frame_valid_q <= frame_valid_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_load) begin
      frame_q <= frame_i;
    end
    if (out_load && frame_valid_q) begin
      out_byte_q <= frame_q.bytes[idx_q];
      out_last_q <= at_last;
      out_err_q  <= frame_q.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

@@ src/motor_command_frame_builder.sv @@
`timescale 1ns / 1ps
// path: request register, then serializer frame register, then master-side byte register
// throughput: one byte per cycle unless m_axis_tready stalls; a request gives 7 or 8 bytes,
// or 1 on a range error, so the byte port sets the pace at which requests are taken
// the next request is registered while the current frame is still being sent
// reset: asynchronous active low; clears all valid flags, ids return to 183 and 172
module motor_command_frame_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // req_type, motor_id, value, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // out_byte
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,  // range_error
  input  logic                          cfg_we_i,
  input  logic [mcfb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                    cfg_data_i
);
  import mcfb_pkg::*;

  logic       req_valid_q, req_valid_d;
  req_t       req_q;
  logic [7:0] receiver_id_q;
  logic [7:0] sender_id_q;
  frame_t     frame;
  logic       frame_ready;
  logic       in_load;

  assign s_axis_tready = !req_valid_q || frame_ready;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req_valid_d = req_valid_q;
    if (frame_ready) begin
      req_valid_d = 1'b0;
    end
    if (in_load) begin
      req_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q   <= 1'b0;
      receiver_id_q <= ReceiverIdReset;
      sender_id_q   <= SenderIdReset;
    end else begin
      req_valid_q <= req_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgReceiverId: receiver_id_q <= cfg_data_i;
          CfgSenderId:   sender_id_q   <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_q <= s_axis_tdata[27:0];
    end
  end

  mcfb_encode u_encode (
    .req_i         (req_q),
    .receiver_id_i (receiver_id_q),
    .sender_id_i   (sender_id_q),
    .frame_o       (frame)
  );

  mcfb_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (req_valid_q),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_err_o     (m_axis_tuser)
  );

endmodule

@@ src/mcfb_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcfb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [7:0]                   m_axis_tdata,
  input logic                         m_axis_tlast,
  input logic                         m_axis_tuser
);

  // an error transaction is a single zero byte that closes its result
  `ASSERT_IMPLY(err_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error result without last")
  `ASSERT_IMPLY(err_is_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0, "error result with nonzero byte")
  // a stalled result holds
  `ASSERT_NEXT(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
  // a frame byte that is not last is followed by more output, never by an error result
  `ASSERT_NEXT(no_err_mid_frame, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !(m_axis_tvalid && m_axis_tuser), "error result inside a frame")

endmodule

bind motor_command_frame_builder mcfb_checker u_mcfb_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import mcfb_pkg::*;

  // parameter numbers carried in the fourth frame byte
  localparam logic [7:0] PrmDefault      = 8'd3;
  localparam logic [7:0] PrmTorqueOff    = 8'd5;
  localparam logic [7:0] PrmBrake        = 8'd6;
  localparam logic [7:0] PrmCmd          = 8'd10;
  localparam logic [7:0] PrmAlarmReset   = 8'd12;
  localparam logic [7:0] PrmPosReset     = 8'd13;
  localparam logic [7:0] PrmMainBc       = 8'd14;
  localparam logic [7:0] PrmMonitorBc    = 8'd15;
  localparam logic [7:0] PrmPresetSave   = 8'd31;
  localparam logic [7:0] PrmPresetRecall = 8'd32;
  localparam logic [7:0] PrmVel          = 8'd130;
  localparam logic [7:0] PrmVelX10       = 8'd131;
  localparam logic [7:0] PrmIdSet        = 8'd133;
  localparam logic [7:0] PrmOpenVel      = 8'd134;
  localparam logic [7:0] PrmBaud         = 8'd135;

  localparam logic [3:0] ReqUnused  = 4'd15;
  localparam int         PresetMax  = 20;
  localparam int         OpenVelMax = 1023;
  localparam int         IdMax      = 253;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePct     = 35;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       range_err;
  } frame_byte_t;

  class frame_checker;
    frame_byte_t expected_bytes[$];
    logic [7:0]  rx_id;
    logic [7:0]  tx_id;
    int unsigned errors;

    function new();
      rx_id  = ReceiverIdReset;
      tx_id  = SenderIdReset;
      errors = 0;
    endfunction

    function void set_ids(logic [7:0] rx, logic [7:0] tx);
      rx_id = rx;
      tx_id = tx;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // build the frame a request produces and queue its bytes
    function void add_request(logic [3:0] kind, logic [7:0] motor, logic [15:0] value);
      logic [7:0]  frame [8];
      logic [7:0]  dst_motor;
      logic [7:0]  param;
      logic [7:0]  d0;
      logic [7:0]  d1;
      logic [7:0]  sum;
      logic [15:0] scaled;
      int          sval;
      int unsigned ndata;
      int unsigned len;
      bit          range_fail;
      frame_byte_t fb;

      sval       = $signed(value);
      dst_motor  = motor;
      param      = 8'd0;
      d0         = 8'd0;
      d1         = 8'd0;
      ndata      = 1;
      range_fail = 1'b0;
      case (kind)
        ReqDefault: begin
          param = PrmDefault;
          d0    = DefaultData;
        end
        ReqTorqueOff: begin
          param = PrmTorqueOff;
          d0    = FlagData;
        end
        ReqBrake: begin
          param = PrmBrake;
          d0    = FlagData;
        end
        ReqCmd: begin
          param = PrmCmd;
          d0    = value[7:0];
        end
        ReqAlarmReset: begin
          param = PrmAlarmReset;
          d0    = FlagData;
        end
        ReqPosReset: begin
          param = PrmPosReset;
          d0    = FlagData;
        end
        ReqMainBc: begin
          param = PrmMainBc;
          d0    = value[7:0];
        end
        ReqMonitorBc: begin
          param = PrmMonitorBc;
          d0    = value[7:0];
        end
        ReqPresetSave, ReqPresetRecall: begin
          range_fail = (sval < 1) || (sval > PresetMax);
          param      = (kind == ReqPresetSave) ? PrmPresetSave : PrmPresetRecall;
          d0         = value[7:0];
        end
        ReqVel: begin
          param = PrmVel;
          ndata = 2;
          d0    = value[7:0];
          d1    = value[15:8];
        end
        ReqVelX10: begin
          scaled = value * 16'd10;
          param  = PrmVelX10;
          ndata  = 2;
          d0     = scaled[7:0];
          d1     = scaled[15:8];
        end
        ReqOpenVel: begin
          range_fail = (sval < -OpenVelMax) || (sval > OpenVelMax);
          param      = PrmOpenVel;
          ndata      = 2;
          d0         = value[7:0];
          d1         = value[15:8];
        end
        ReqIdSet: begin
          range_fail = (sval < 1) || (sval > IdMax);
          param      = PrmIdSet;
          ndata      = 2;
          dst_motor  = IdSetMotor;
          d0         = KeyData;
          d1         = value[7:0];
        end
        ReqBaud: begin
          param = PrmBaud;
          ndata = 2;
          d0    = KeyData;
          d1    = value[7:0];
        end
        default: begin
          range_fail = 1'b1;
        end
      endcase

      if (range_fail) begin
        fb.data      = 8'd0;
        fb.last      = 1'b1;
        fb.range_err = 1'b1;
        expected_bytes.push_back(fb);
        return;
      end

      frame[0] = rx_id;
      frame[1] = tx_id;
      frame[2] = dst_motor;
      frame[3] = param;
      frame[4] = ndata[7:0];
      frame[5] = d0;
      frame[6] = d1;
      len      = 5 + ndata;
      sum      = 8'd0;
      for (int i = 0; i < len; i++) sum = sum + frame[i];
      // checksum makes the whole frame sum to zero
      frame[len] = 8'd0 - sum;
      for (int i = 0; i <= len; i++) begin
        fb.data      = frame[i];
        fb.last      = (i == len);
        fb.range_err = 1'b0;
        expected_bytes.push_back(fb);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] data, logic last, logic range_err);
      frame_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b err %0b",
                                  data, last, range_err));
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (data !== exp_b.data)
        report_mismatch($sformatf("byte got %02h expected %02h", data, exp_b.data));
      if (last !== exp_b.last)
        report_mismatch($sformatf("last got %0b expected %0b", last, exp_b.last));
      if (range_err !== exp_b.range_err)
        report_mismatch($sformatf("range_error got %0b expected %0b",
                                  range_err, exp_b.range_err));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;  // req_type, motor_id, value, zero pad
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;  // out_byte
  logic                m_axis_tlast;
  logic                m_axis_tuser;  // range_error
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [7:0]          cfg_data_i;

  bit src_idle_en;
  bit sink_idle_en;

  frame_checker frames;

  motor_command_frame_builder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      frames.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  task automatic send_request(logic [3:0] kind, logic [7:0] motor, logic [15:0] value);
    while (src_idle_en && ($urandom_range(99) < IdlePct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, value, motor, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    frames.add_request(kind, motor, value);
  endtask

  function automatic logic [15:0] pick_value(logic [3:0] kind);
    int lim_lo;
    int lim_hi;
    int v;
    int r;
    r = $urandom_range(99);
    case (kind)
      ReqPresetSave, ReqPresetRecall: begin
        lim_lo = 1;
        lim_hi = PresetMax;
      end
      ReqOpenVel: begin
        lim_lo = -OpenVelMax;
        lim_hi = OpenVelMax;
      end
      ReqIdSet: begin
        lim_lo = 1;
        lim_hi = IdMax;
      end
      default: begin
        return 16'($urandom_range(16'hFFFF));
      end
    endcase
    // mostly legal arguments, some on the edges of the range, some anything
    if (r < 70) begin
      v = lim_lo + int'($urandom_range(lim_hi - lim_lo));
    end else if (r < 88) begin
      case ($urandom_range(3))
        0:       v = lim_lo - 1;
        1:       v = lim_lo;
        2:       v = lim_hi;
        default: v = lim_hi + 1;
      endcase
    end else begin
      v = $urandom_range(16'hFFFF);
    end
    return v[15:0];
  endfunction

  task automatic send_random();
    logic [3:0] kind;
    kind = 4'($urandom_range(15));
    send_request(kind, 8'($urandom_range(255)), pick_value(kind));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_ids(logic [7:0] rx, logic [7:0] tx);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgReceiverId;
    cfg_data_i <= rx;
    @(posedge clk_i);
    cfg_idx_i  <= CfgSenderId;
    cfg_data_i <= tx;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frames.set_ids(rx, tx);
  endtask

  initial begin
    frames        = new();
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgReceiverId;
    cfg_data_i    = 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edges of every request kind, run with the reset ids
    send_request(ReqDefault,      8'd0,   16'h0000);
    send_request(ReqTorqueOff,    8'd255, 16'hFFFF);
    send_request(ReqBrake,        8'h5A,  16'h0000);
    send_request(ReqCmd,          8'hA5,  16'h80C3);
    send_request(ReqAlarmReset,   8'd1,   16'h7FFF);
    send_request(ReqPosReset,     8'd2,   16'h1234);
    send_request(ReqMainBc,       8'd3,   16'h00A5);
    send_request(ReqMonitorBc,    8'd4,   16'hFF5A);
    send_request(ReqPresetSave,   8'd5,   16'd0);
    send_request(ReqPresetSave,   8'd6,   16'd1);
    send_request(ReqPresetRecall, 8'd7,   16'd20);
    send_request(ReqPresetRecall, 8'd8,   16'd21);
    send_request(ReqPresetRecall, 8'd9,   16'hFFFF);
    send_request(ReqVel,          8'd10,  16'h7FFF);
    send_request(ReqVel,          8'd11,  16'h8000);
    send_request(ReqVelX10,       8'd12,  16'h8000);
    send_request(ReqVelX10,       8'd13,  16'd6554);  // times ten wraps past 16 bits
    send_request(ReqOpenVel,      8'd14,  16'hFC00);
    send_request(ReqOpenVel,      8'd15,  16'hFC01);
    send_request(ReqOpenVel,      8'd16,  16'h03FF);
    send_request(ReqOpenVel,      8'd17,  16'h0400);
    send_request(ReqIdSet,        8'd18,  16'd0);
    send_request(ReqIdSet,        8'd19,  16'd1);
    send_request(ReqIdSet,        8'd20,  16'd253);
    send_request(ReqIdSet,        8'd21,  16'd254);
    send_request(ReqBaud,         8'd22,  16'h12AB);
    send_request(ReqUnused,       8'd255, 16'h0000);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_ids(8'd0, 8'd0);
        1:       write_ids(8'd255, 8'd255);
        2:       write_ids(8'($urandom_range(255)), 8'($urandom_range(255)));
        default: write_ids(8'd255, 8'd0);
      endcase
      // one phase runs back to back on both sides
      src_idle_en  = (phase != 2);
      sink_idle_en = (phase != 2);
      repeat (21) send_random();
      wait_idle();
    end

    if (frames.errors == 0 && frames.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/mcfb_pkg.sv
src/mcfb_encode.sv
src/mcfb_serializer.sv
src/motor_command_frame_builder.sv
src/mcfb_checker.sv
sim/tb.sv
